[rtl/adi_pkg.sv]
package adi_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned MagW   = 31;

  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChPlus  = 8'h2b;
  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  localparam logic [MagW-1:0] MagLimit = 31'h7fff_ffff;

  typedef enum logic [1:0] {
    PH_BLANK  = 2'd0,
    PH_PLUS   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_OVF = 2'd2
  } status_e;

  typedef struct packed {
    phase_e          phase;
    logic [MagW-1:0] mag;
    logic            neg;
    status_e         err;
  } parse_state_t;

  localparam parse_state_t StateInit = '{
    phase: PH_BLANK,
    mag:   '0,
    neg:   1'b0,
    err:   ST_OK
  };

endpackage

[rtl/adi_step.sv]
module adi_step
  import adi_pkg::*;
(
  input  parse_state_t      state_i,
  input  logic [CharW-1:0]  char_code_i,
  output parse_state_t      state_o,
  output logic              term_o,
  output logic [ValueW-1:0] value_o,
  output status_e           status_o
);

  logic            is_digit;
  logic [3:0]      digit;
  logic [MagW+3:0] mag_ext;
  logic [MagW+3:0] prod;
  logic            ovf;

  assign term_o   = (char_code_i == ChNul);
  assign is_digit = (char_code_i >= ChZero) && (char_code_i <= ChNine);
  // The digit codes sit at 0x30 to 0x39, so the low nibble is the digit.
  assign digit    = char_code_i[3:0];

  // magnitude * 10 + digit as two shifts and two adds.
  assign mag_ext = {4'b0, state_i.mag};
  assign prod    = (mag_ext << 3) + (mag_ext << 1) + {{(MagW){1'b0}}, digit};
  assign ovf     = prod > {4'b0, MagLimit};

  always_comb begin
    if (state_i.err != ST_OK) begin
      value_o = '0;
    end else if (state_i.neg) begin
      value_o = ValueW'(0) - {1'b0, state_i.mag};
    end else begin
      value_o = {1'b0, state_i.mag};
    end
  end

  assign status_o = state_i.err;

  always_comb begin
    state_o = state_i;
    if (term_o) begin
      state_o = StateInit;
    end else if (state_i.err == ST_OK) begin
      if (is_digit) begin
        state_o.phase = PH_DIGITS;
        if (ovf) begin
          state_o.err = ST_OVF;
        end else begin
          state_o.mag = prod[MagW-1:0];
        end
      end else begin
        case (state_i.phase)
          PH_BLANK: begin
            if (char_code_i == ChSpace || char_code_i == ChTab) begin
              state_o.phase = PH_BLANK;
            end else if (char_code_i == ChPlus) begin
              state_o.phase = PH_PLUS;
            end else if (char_code_i == ChMinus) begin
              state_o.neg   = 1'b1;
              state_o.phase = PH_DIGITS;
            end else begin
              state_o.err = ST_BAD;
            end
          end
          PH_PLUS: begin
            if (char_code_i == ChMinus) begin
              state_o.neg   = 1'b1;
              state_o.phase = PH_DIGITS;
            end else begin
              state_o.err = ST_BAD;
            end
          end
          default: begin
            state_o.err = ST_BAD;
          end
        endcase
      end
    end
  end

endmodule

[rtl/ascii_decimal_to_int_parser_unit.sv]
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    char_code_i[7:0]
// out      output     out_valid_o / out_stall_i  value_o[31:0] signed, status_o[1:0]
//
// One character per cycle is taken while in_stall_o is low; each beat is held
// in the input register, where the parse state is updated, and a terminator's
// result is then registered into the output register.
// Reset clears the parse state and both valid flags.
// Only a terminator waiting in the input register is held back by a stalled,
// full output register; other characters pass on regardless.
module ascii_decimal_to_int_parser_unit
  import adi_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CharW-1:0]         char_code_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ValueW-1:0] value_o,
  output logic [1:0]               status_o
);

  logic              in_vld_q;
  logic [CharW-1:0]  char_q;
  parse_state_t      state_q;
  parse_state_t      state_d;
  logic              term;
  logic [ValueW-1:0] value_d;
  status_e           status_d;
  logic              out_vld_q;
  logic [ValueW-1:0] value_q;
  status_e           status_q;
  logic              advance;
  logic              in_accept;

  adi_step u_step (
    .state_i     (state_q),
    .char_code_i (char_q),
    .state_o     (state_d),
    .term_o      (term),
    .value_o     (value_d),
    .status_o    (status_d)
  );

  assign advance    = in_vld_q && (!term || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      state_q   <= StateInit;
      out_vld_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && term) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q <= char_code_i;
    end
    if (advance && term) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  // An error result always carries a zero value.
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (status_q != ST_OK) |-> value_q == '0)
    else $error("error result with non-zero value");

  // Once an error is latched, only a terminator may change the parse state.
  a_err_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !term && (state_q.err != ST_OK) |=> $stable(state_q))
    else $error("parse state changed after an error");

  // A terminator clears the parse state.
  a_term_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && term |=> state_q == StateInit)
    else $error("parse state not cleared after a terminator");

  // Results only ever follow a terminator passing through.
  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(advance && term))
    else $error("result without a terminator");

endmodule

[dv/tb_top.sv]
module tb_top;
  import adi_pkg::*;

  localparam int unsigned RandChars  = 1250;
  localparam int unsigned IdleLimit  = 1000;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned LongHold   = 120;

  typedef struct {
    logic signed [ValueW-1:0] value;
    status_e                  status;
  } int_result_t;

  // A row with pinned set carries a result written out by hand.
  typedef struct {
    bit                       pinned;
    logic signed [ValueW-1:0] value;
    status_e                  status;
  } hand_result_t;

  typedef struct {
    string     text;
    bit        pinned;
    int        value;
    status_e   status;
  } line_row_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [CharW-1:0]         char_code_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [ValueW-1:0] value_o;
  logic [1:0]               status_o;

  // Parser state as seen by the predictor.
  phase_e          ph;
  logic [MagW-1:0] mag;
  logic            neg;
  status_e         err;

  int_result_t  pending_ints[$];
  hand_result_t hand_results[$];
  int unsigned  mismatches = 0;
  int unsigned  chars_sent = 0;
  int unsigned  idle_cycles = 0;
  bit           tx_quiet = 1'b0;
  bit           rx_quiet = 1'b0;

  line_row_t directed_lines [8] = '{
    '{"",            1'b1, 0,          ST_OK},
    '{"-",           1'b1, 0,          ST_OK},
    '{"\3775",       1'b1, 0,          ST_BAD},
    '{"\t +-9",      1'b1, -9,         ST_OK},
    '{"-+",          1'b1, 0,          ST_BAD},
    '{"2147483647",  1'b1, 2147483647, ST_OK},
    '{"-2147483648", 1'b1, 0,          ST_OVF},
    '{" 7 8",        1'b0, 0,          ST_OK}
  };

  ascii_decimal_to_int_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void clear_parse();
    ph  = PH_BLANK;
    mag = '0;
    neg = 1'b0;
    err = ST_OK;
  endfunction

  // Advances the parse by one character; returns 1 on every terminator, which yields a result.
  function automatic bit parse_char(input logic [CharW-1:0] c, output int_result_t res);
    longint grown;
    res.value  = '0;
    res.status = ST_OK;
    if (c == ChNul) begin
      if (err == ST_OK) begin
        res.value = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
      res.status = err;
      clear_parse();
      return 1'b1;
    end
    if (err != ST_OK) begin
      return 1'b0;
    end
    if (c >= ChZero && c <= ChNine) begin
      grown = longint'(mag) * 10 + longint'(c - ChZero);
      if (grown > longint'(MagLimit)) begin
        err = ST_OVF;
      end else begin
        mag = grown[MagW-1:0];
      end
      ph = PH_DIGITS;
    end else begin
      case (ph)
        PH_BLANK: begin
          if (c == ChSpace || c == ChTab) begin
          end else if (c == ChPlus) begin
            ph = PH_PLUS;
          end else if (c == ChMinus) begin
            neg = 1'b1;
            ph  = PH_DIGITS;
          end else begin
            err = ST_BAD;
          end
        end
        PH_PLUS: begin
          if (c == ChMinus) begin
            neg = 1'b1;
            ph  = PH_DIGITS;
          end else begin
            err = ST_BAD;
          end
        end
        default: err = ST_BAD;
      endcase
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    int_result_t  want;
    hand_result_t hand;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_ints.size() == 0) begin
          report_mismatch("unexpected result beat, value", value_o, 0);
        end else begin
          want = pending_ints.pop_front();
          if (value_o !== want.value) begin
            report_mismatch("value", value_o, want.value);
          end
          if (status_o !== want.status) begin
            report_mismatch("status", status_o, want.status);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (parse_char(char_code_i, want)) begin
          if (hand_results.size() != 0) begin
            hand = hand_results.pop_front();
            if (hand.pinned) begin
              want.value  = hand.value;
              want.status = hand.status;
            end
          end
          pending_ints.push_back(want);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IdleLimit) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [CharW-1:0] c);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_line(input logic [CharW-1:0] line[$]);
    foreach (line[i]) send_char(line[i]);
    send_char(ChNul);
  endtask

  // Result side: a random hold-off before each beat outside quiet spells, and twice a long one
  // so that a terminator backs up behind a full output register.
  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    taken = 0;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 5) == 0) rx_quiet = !rx_quiet;
      hold = rx_quiet ? 0 : $urandom_range(0, 11);
      if (taken == 12 || taken == 80) hold = LongHold;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin : char_source
    logic [CharW-1:0] line[$];
    hand_result_t     hand;
    string            digits;
    int unsigned      kind;
    clear_parse();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_lines[r]) begin
      line.delete();
      for (int i = 0; i < directed_lines[r].text.len(); i++) begin
        line.push_back(directed_lines[r].text[i]);
      end
      hand.pinned = directed_lines[r].pinned;
      hand.value  = directed_lines[r].value;
      hand.status = directed_lines[r].status;
      hand_results.push_back(hand);
      send_line(line);
    end

    while (chars_sent < RandChars) begin
      if ($urandom_range(0, 4) == 0) tx_quiet = !tx_quiet;
      line.delete();
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        // Noise: arbitrary non-terminator bytes.
        repeat ($urandom_range(1, 8)) line.push_back(8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(0, 2)) line.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
        case ($urandom_range(0, 5))
          0: line.push_back(ChPlus);
          1: line.push_back(ChMinus);
          2: begin
            line.push_back(ChPlus);
            line.push_back(ChMinus);
          end
          default: ;
        endcase
        case ($urandom_range(0, 7))
          0:       digits = "";
          1, 2:    digits = $sformatf("%0d", 2147483600 + longint'($urandom_range(0, 99)));
          3:       digits = $sformatf("%0d%0d", $urandom_range(1, 99999), $urandom);
          4:       digits = $sformatf("00%0d", $urandom_range(0, 999));
          default: digits = $sformatf("%0d", $urandom_range(0, 999999));
        endcase
        for (int i = 0; i < digits.len(); i++) line.push_back(digits[i]);
        // Broken sequences: a stray sign or blank, or any non-terminator byte.
        if (kind >= 70 && kind < 80) begin
          case ($urandom_range(0, 2))
            0:       line.insert($urandom_range(0, line.size()), ChPlus);
            1:       line.insert($urandom_range(0, line.size()), ChMinus);
            default: line.insert($urandom_range(0, line.size()), ChSpace);
          endcase
        end else if (kind >= 80) begin
          line.insert($urandom_range(0, line.size()), 8'($urandom_range(1, 255)));
        end
      end
      send_line(line);
    end
    in_valid_i <= 1'b0;

    while (pending_ints.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
